// File: sv/rcs_pkg.sv
package rcs_pkg;

   localparam int CHANNELS = 3;
   localparam int Q16_W = 24;

   localparam logic [7:0] FULL_SCALE = 8'd255;
   localparam logic [6:0] PCT_MAX = 7'd100;
   localparam logic [Q16_W-1:0] ONE_Q16 = 24'd65536;
   localparam logic [30:0] PCT_ROUND = 31'd50;

   // Division by 100 of a 31-bit value: multiply by ceil(2^38 / 100), keep bits 38 and up.
   localparam logic [31:0] RECIP_100 = 32'd2748779070;
   localparam int RECIP_SHIFT = 38;

   typedef logic [7:0] pix_type;
   typedef logic [CHANNELS-1:0][7:0] trio_type;
   typedef logic [Q16_W-1:0] q16_type;

   // Queue entry: the pixel plus the statistics that were current when it arrived.
   typedef struct packed {
      trio_type pix;
      trio_type lo;
      trio_type hi;
   } item_type;

   typedef struct packed {
      logic start;
      pix_type divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      q16_type quot;
   } div_rsp_type;

endpackage

// File: sv/rcs_front.sv
module rcs_front (
   input logic clock,
   input logic reset,
   input logic push,
   input logic full,
   input logic mode,
   input logic first_of_frame,
   input rcs_pkg::pix_type blue,
   input rcs_pkg::pix_type green,
   input rcs_pkg::pix_type red,
   output logic enq,
   output rcs_pkg::item_type enq_item
);

   rcs_pkg::trio_type lo_ff;
   rcs_pkg::trio_type lo_in;
   rcs_pkg::trio_type hi_ff;
   rcs_pkg::trio_type hi_in;
   rcs_pkg::trio_type pix;
   logic take;
   logic gather;

   assign pix = {red, green, blue};
   assign take = push && !full;
   assign gather = take && !mode;
   assign enq = take && mode;

   always_comb begin
      for (int c = 0; c < rcs_pkg::CHANNELS; c++) begin
         if (first_of_frame) begin
            lo_in[c] = pix[c];
            hi_in[c] = pix[c];
         end else begin
            lo_in[c] = (pix[c] < lo_ff[c]) ? pix[c] : lo_ff[c];
            hi_in[c] = (pix[c] > hi_ff[c]) ? pix[c] : hi_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= {rcs_pkg::CHANNELS{rcs_pkg::FULL_SCALE}};
         hi_ff <= '0;
      end else if (gather) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   assign enq_item.pix = pix;
   assign enq_item.lo = lo_ff;
   assign enq_item.hi = hi_ff;

endmodule

// File: sv/rcs_queue.sv
module rcs_queue #(
   parameter int DEPTH = 4
) (
   input logic clock,
   input logic reset,
   input logic wr_en,
   input rcs_pkg::item_type wr_data,
   input logic rd_en,
   output rcs_pkg::item_type rd_data,
   output logic full,
   output logic empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   rcs_pkg::item_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic do_wr;
   logic do_rd;

   assign full = (cnt_ff == FULL_CNT);
   assign empty = (cnt_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

// File: sv/rcs_div.sv
module rcs_div (
   input logic clock,
   input logic reset,
   input rcs_pkg::div_req_type req,
   output rcs_pkg::div_rsp_type rsp
);

   localparam int STEPS = rcs_pkg::Q16_W;
   localparam int CNT_W = $clog2(STEPS);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   // Restoring division of (255 << 16) + d/2 by d, one quotient bit per cycle.
   // The numerator shifts out of the top of nq_ff while quotient bits enter at the bottom.
   logic busy_ff;
   logic done_ff;
   logic [CNT_W-1:0] cnt_ff;
   rcs_pkg::pix_type rem_ff;
   rcs_pkg::pix_type d_ff;
   rcs_pkg::q16_type nq_ff;
   logic [8:0] trial;
   logic [8:0] diff;
   logic ge;

   assign trial = {rem_ff, nq_ff[STEPS-1]};
   assign ge = (trial >= {1'b0, d_ff});
   assign diff = trial - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
            rem_ff <= '0;
            d_ff <= req.divisor;
            nq_ff <= {rcs_pkg::FULL_SCALE, 16'h0000} + STEPS'(req.divisor >> 1);
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[7:0] : trial[7:0];
            nq_ff <= {nq_ff[STEPS-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = nq_ff;

endmodule

// File: sv/rcs_back.sv
module rcs_back (
   input logic clock,
   input logic reset,
   input logic csr_wr_en,
   input logic [6:0] csr_wr_data,
   input logic q_empty,
   input rcs_pkg::item_type q_item,
   output logic q_pop,
   output rcs_pkg::div_req_type div_req,
   input rcs_pkg::div_rsp_type div_rsp,
   input logic pop,
   output logic empty,
   output rcs_pkg::pix_type blue,
   output rcs_pkg::pix_type green,
   output rcs_pkg::pix_type red
);

   localparam int CH = rcs_pkg::CHANNELS;
   localparam int QW = rcs_pkg::Q16_W;
   localparam logic [1:0] LAST_CHAN = 2'(CH - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_SCALE_MUL,
      S_SCALE_FIN,
      S_SHIFT_MUL,
      S_STORE,
      S_SUB,
      S_MUL,
      S_OUT
   } state_type;

   state_type state_ff;
   logic [6:0] pct_ff;
   rcs_pkg::item_type item_ff;
   logic [1:0] chan_ff;

   // Per-channel cache of scale and shift for the last min and max seen on that channel.
   logic [CH-1:0] cache_vld_ff;
   rcs_pkg::trio_type cache_lo_ff;
   rcs_pkg::trio_type cache_hi_ff;
   logic [CH-1:0][QW-1:0] cache_scale_ff;
   logic [CH-1:0][QW-1:0] cache_shift_ff;

   logic div_start_ff;
   rcs_pkg::pix_type div_d_ff;
   logic [30:0] numr_ff;
   logic [62:0] prod_ff;
   rcs_pkg::q16_type scale_ff;

   logic [CH-1:0] pos_ff;
   logic [CH-1:0][QW-1:0] x_ff;
   logic [CH-1:0][2*QW-1:0] mp_ff;

   logic out_vld_ff;
   rcs_pkg::trio_type out_ff;

   rcs_pkg::pix_type lo_c;
   rcs_pkg::pix_type hi_c;
   logic hit;
   logic [14:0] lo_pct;
   logic [30:0] shift_numr;
   rcs_pkg::q16_type ratio_excess;
   logic [30:0] scale_numr;
   rcs_pkg::q16_type quot100;
   logic [CH-1:0][QW-1:0] pq;
   logic [CH-1:0][16:0] rnd;
   rcs_pkg::trio_type res;
   logic out_free;

   assign lo_c = item_ff.lo[chan_ff];
   assign hi_c = item_ff.hi[chan_ff];
   assign hit = cache_vld_ff[chan_ff] && (cache_lo_ff[chan_ff] == lo_c)
                && (cache_hi_ff[chan_ff] == hi_c);

   assign lo_pct = 15'(lo_c) * 15'(pct_ff);
   assign shift_numr = {lo_pct, 16'h0000} + rcs_pkg::PCT_ROUND;
   assign ratio_excess = div_rsp.quot - rcs_pkg::ONE_Q16;
   assign scale_numr = 31'(ratio_excess) * 31'(pct_ff) + rcs_pkg::PCT_ROUND;
   assign quot100 = prod_ff[rcs_pkg::RECIP_SHIFT +: QW];

   always_comb begin
      for (int c = 0; c < CH; c++) begin
         pq[c] = {item_ff.pix[c], 16'h0000};
         rnd[c] = 17'((49'(mp_ff[c]) + (49'd1 << 31)) >> 32);
         if (!pos_ff[c]) begin
            res[c] = '0;
         end else if (rnd[c] > 17'(rcs_pkg::FULL_SCALE)) begin
            res[c] = rcs_pkg::FULL_SCALE;
         end else begin
            res[c] = rnd[c][7:0];
         end
      end
   end

   assign out_free = !out_vld_ff || pop;
   assign q_pop = (state_ff == S_IDLE) && !q_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pct_ff <= '0;
         chan_ff <= '0;
         cache_vld_ff <= '0;
         div_start_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         if (pop && out_vld_ff) begin
            out_vld_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            pct_ff <= (csr_wr_data > rcs_pkg::PCT_MAX) ? rcs_pkg::PCT_MAX : csr_wr_data;
            cache_vld_ff <= '0;
         end
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  item_ff <= q_item;
                  chan_ff <= '0;
                  state_ff <= S_CHECK;
               end
            end
            S_CHECK: begin
               if (hit) begin
                  if (chan_ff == LAST_CHAN) begin
                     state_ff <= S_SUB;
                  end else begin
                     chan_ff <= chan_ff + 1'b1;
                  end
               end else if (hi_c > lo_c) begin
                  div_start_ff <= 1'b1;
                  div_d_ff <= hi_c - lo_c;
                  state_ff <= S_DIV;
               end else begin
                  // Flat channel or no statistics yet: unit scale.
                  scale_ff <= rcs_pkg::ONE_Q16;
                  numr_ff <= shift_numr;
                  state_ff <= S_SHIFT_MUL;
               end
            end
            S_DIV: begin
               if (div_rsp.done) begin
                  numr_ff <= scale_numr;
                  state_ff <= S_SCALE_MUL;
               end
            end
            S_SCALE_MUL: begin
               prod_ff <= 63'(numr_ff) * 63'(rcs_pkg::RECIP_100);
               state_ff <= S_SCALE_FIN;
            end
            S_SCALE_FIN: begin
               scale_ff <= rcs_pkg::ONE_Q16 + quot100;
               numr_ff <= shift_numr;
               state_ff <= S_SHIFT_MUL;
            end
            S_SHIFT_MUL: begin
               prod_ff <= 63'(numr_ff) * 63'(rcs_pkg::RECIP_100);
               state_ff <= S_STORE;
            end
            S_STORE: begin
               cache_vld_ff[chan_ff] <= 1'b1;
               cache_lo_ff[chan_ff] <= lo_c;
               cache_hi_ff[chan_ff] <= hi_c;
               cache_scale_ff[chan_ff] <= scale_ff;
               cache_shift_ff[chan_ff] <= quot100;
               if (chan_ff == LAST_CHAN) begin
                  state_ff <= S_SUB;
               end else begin
                  chan_ff <= chan_ff + 1'b1;
                  state_ff <= S_CHECK;
               end
            end
            S_SUB: begin
               for (int c = 0; c < CH; c++) begin
                  pos_ff[c] <= pq[c] > cache_shift_ff[c];
                  x_ff[c] <= pq[c] - cache_shift_ff[c];
               end
               state_ff <= S_MUL;
            end
            S_MUL: begin
               for (int c = 0; c < CH; c++) begin
                  mp_ff[c] <= (2*QW)'(cache_scale_ff[c]) * (2*QW)'(x_ff[c]);
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_free) begin
                  out_ff <= res;
                  out_vld_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign div_req.start = div_start_ff;
   assign div_req.divisor = div_d_ff;
   assign empty = !out_vld_ff;
   assign blue = out_ff[0];
   assign green = out_ff[1];
   assign red = out_ff[2];

endmodule

// File: sv/rgb_contrast_stretch_top.sv
// Channel   Handshake             Carries
// req       push / full           mode, first_of_frame, blue/green/red sample
// rsp       empty / pop           stretched blue/green/red sample
// csr       csr_wr_en             stretch_percent (0..100, larger values act as 100)
//
// A gather item is taken whenever the queue is not full; it gives no item.
// A stretch item whose three channels all hit the scale cache goes on to subtract, multiply
// and output; a missing channel adds the 24-step divider, two multiply-by-reciprocal steps
// and the cache store, or only shift multiply and store when flat or with no statistics.
// Reset clears statistics, percent, cache, queue and the output valid bit.
// full is high while QUEUE_DEPTH stretch items wait; a result held for pop stops the back end
// after it has finished one more item.
module rgb_contrast_stretch_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input logic req_mode,
   input logic req_first_of_frame,
   input logic [7:0] req_blue_in,
   input logic [7:0] req_green_in,
   input logic [7:0] req_red_in,
   output logic empty,
   input logic pop,
   output logic [7:0] rsp_blue_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_red_out,
   input logic csr_wr_en,
   input logic [6:0] csr_wr_data
);

   logic enq;
   rcs_pkg::item_type enq_item;
   logic q_pop;
   logic q_empty;
   rcs_pkg::item_type q_item;
   rcs_pkg::div_req_type div_req;
   rcs_pkg::div_rsp_type div_rsp;

   rcs_front u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .mode(req_mode),
      .first_of_frame(req_first_of_frame),
      .blue(req_blue_in),
      .green(req_green_in),
      .red(req_red_in),
      .enq(enq),
      .enq_item(enq_item)
   );

   rcs_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .wr_en(enq),
      .wr_data(enq_item),
      .rd_en(q_pop),
      .rd_data(q_item),
      .full(full),
      .empty(q_empty)
   );

   rcs_div u_div (
      .clock(clock),
      .reset(reset),
      .req(div_req),
      .rsp(div_rsp)
   );

   rcs_back u_back (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .q_empty(q_empty),
      .q_item(q_item),
      .q_pop(q_pop),
      .div_req(div_req),
      .div_rsp(div_rsp),
      .pop(pop),
      .empty(empty),
      .blue(rsp_blue_out),
      .green(rsp_green_out),
      .red(rsp_red_out)
   );

endmodule

// File: sv/rcs_check.sv
module rcs_check (
   input logic clock,
   input logic reset,
   input logic push,
   input logic full,
   input logic req_mode,
   input logic empty,
   input logic pop,
   input logic [7:0] rsp_blue_out,
   input logic [7:0] rsp_green_out,
   input logic [7:0] rsp_red_out
);

   // Stretch items accepted and not yet popped.
   logic [7:0] pending_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         case ({push && !full && req_mode, pop && !empty})
            2'b10: pending_ff <= pending_ff + 1'b1;
            2'b01: pending_ff <= pending_ff - 1'b1;
            default: pending_ff <= pending_ff;
         endcase
      end
   end

   a_reset_clear: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queue or output not cleared by reset");

   a_item_held: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty)
      else $error("waiting item dropped without pop");

   a_payload_stable: assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> $stable({rsp_blue_out, rsp_green_out, rsp_red_out}))
      else $error("waiting item changed without pop");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !empty |-> pending_ff != 8'd0)
      else $error("item shown with no stretch item outstanding");

endmodule

bind rgb_contrast_stretch_top rcs_check u_rcs_check (
   .clock(clock),
   .reset(reset),
   .push(push),
   .full(full),
   .req_mode(req_mode),
   .empty(empty),
   .pop(pop),
   .rsp_blue_out(rsp_blue_out),
   .rsp_green_out(rsp_green_out),
   .rsp_red_out(rsp_red_out)
);
